### sv/y86_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y86_pkg
// Shared types, codes and decode helpers for the sequential Y86-64 core.
// ----------------------------------------------------------------------------
package y86_pkg;

  localparam int MEM_BYTES = 4096;
  localparam int AW        = $clog2(MEM_BYTES);
  localparam logic [63:0] MEM_LIM  = 64'(MEM_BYTES);
  localparam logic [63:0] ADDR_MAX = MEM_LIM - 64'd8;

  localparam logic [3:0] NO_REG = 4'hF;
  localparam logic [3:0] RSP_ID = 4'd4;

  localparam logic [3:0] I_HALT   = 4'h0;
  localparam logic [3:0] I_NOP    = 4'h1;
  localparam logic [3:0] I_RRMOVQ = 4'h2;
  localparam logic [3:0] I_IRMOVQ = 4'h3;
  localparam logic [3:0] I_RMMOVQ = 4'h4;
  localparam logic [3:0] I_MRMOVQ = 4'h5;
  localparam logic [3:0] I_OPQ    = 4'h6;
  localparam logic [3:0] I_JXX    = 4'h7;
  localparam logic [3:0] I_CALL   = 4'h8;
  localparam logic [3:0] I_RET    = 4'h9;
  localparam logic [3:0] I_PUSHQ  = 4'hA;
  localparam logic [3:0] I_POPQ   = 4'hB;

  localparam logic [3:0] F_ADD = 4'h0;
  localparam logic [3:0] F_SUB = 4'h1;
  localparam logic [3:0] F_AND = 4'h2;
  localparam logic [3:0] F_XOR = 4'h3;

  localparam logic [3:0] C_ALW = 4'h0;
  localparam logic [3:0] C_LE  = 4'h1;
  localparam logic [3:0] C_L   = 4'h2;
  localparam logic [3:0] C_E   = 4'h3;
  localparam logic [3:0] C_NE  = 4'h4;
  localparam logic [3:0] C_GE  = 4'h5;
  localparam logic [3:0] C_G   = 4'h6;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_HLT = 2'd1,
    ST_ADR = 2'd2,
    ST_INS = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_AND,
    ALU_XOR,
    ALU_ZERO
  } alu_fn_t;

  typedef struct packed {
    logic zf;
    logic sf;
    logic of;
  } cc_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FB0,
    S_FREG,
    S_FC,
    S_RDA,
    S_RDB,
    S_EXEC,
    S_MEMW,
    S_MEMR,
    S_WBE,
    S_WBM,
    S_OUT
  } state_t;

  function automatic logic need_reg(input logic [3:0] ic);
    case (ic) inside
      I_RRMOVQ, I_IRMOVQ, I_RMMOVQ, I_MRMOVQ, I_OPQ, I_PUSHQ, I_POPQ: need_reg = 1'b1;
      default: need_reg = 1'b0;
    endcase
  endfunction

  function automatic logic need_imm(input logic [3:0] ic);
    case (ic) inside
      I_IRMOVQ, I_RMMOVQ, I_MRMOVQ, I_JXX, I_CALL: need_imm = 1'b1;
      default: need_imm = 1'b0;
    endcase
  endfunction

  function automatic logic cond_ok(input cc_t cc, input logic [3:0] fn);
    logic lt;
    lt = cc.sf ^ cc.of;
    case (fn)
      C_ALW:   cond_ok = 1'b1;
      C_LE:    cond_ok = lt | cc.zf;
      C_L:     cond_ok = lt;
      C_E:     cond_ok = cc.zf;
      C_NE:    cond_ok = ~cc.zf;
      C_GE:    cond_ok = ~lt;
      C_G:     cond_ok = ~lt & ~cc.zf;
      default: cond_ok = 1'b0;
    endcase
  endfunction

endpackage

### sv/y86_sequential_processor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y86_sequential_processor
// Sequential Y86-64 core: byte loads into main memory, one instruction per
// execute word, sequenced over a byte-wide memory port and one shared ALU.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  in      | in_valid in_stall in_op in_load_*       | word in
//  out     | out_valid out_stall out_pc ... out_store_* | word out
//
//  A load word writes its byte into memory. An execute word fetches one
//  instruction byte a cycle (up to 10), and may then read 8 data bytes one a
//  cycle through the registered read port or write 8 data bytes.
//  After reset, memory is zeroed one byte a cycle, with in_stall high
//  meanwhile. One word is in flight at a time; in_stall is high until
//  the result word is taken.
// ----------------------------------------------------------------------------
module y86_sequential_processor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [11:0] in_load_addr,
  input  logic [7:0]  in_load_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [63:0] out_pc,
  output logic [1:0]  out_status,
  output logic        out_zero_flag,
  output logic        out_sign_flag,
  output logic        out_overflow_flag,
  output logic [3:0]  out_e_dest,
  output logic signed [63:0] out_e_value,
  output logic [3:0]  out_m_dest,
  output logic signed [63:0] out_m_value,
  output logic        out_store_done,
  output logic [11:0] out_store_addr,
  output logic signed [63:0] out_store_value
);

  localparam int AW = y86_pkg::AW;

  y86_pkg::state_t state_r, state_nxt;
  y86_pkg::stat_t  stat_r, stat_nxt;
  y86_pkg::cc_t    cc_r, cc_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [63:0] pc_r, pc_nxt;
  logic [63:0] faddr_r, faddr_nxt;
  logic        rdok_r, rdok_nxt;
  logic [3:0]  icode_r, icode_nxt, ifun_r, ifun_nxt;
  logic [3:0]  ra_r, ra_nxt, rb_r, rb_nxt;
  logic [63:0] valc_r, valc_nxt, vala_r, vala_nxt, valb_r, valb_nxt;
  logic [63:0] vale_r, vale_nxt, valm_r, valm_nxt;
  logic [63:0] wdata_r, wdata_nxt;
  logic [AW-1:0] maddr_r, maddr_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        cnd_r, cnd_nxt;
  logic [3:0]  edest_r, edest_nxt, mdest_r, mdest_nxt;
  logic        st_done_r, st_done_nxt;
  logic [11:0] st_addr_r, st_addr_nxt;
  logic [63:0] st_val_r, st_val_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rd, fbyte;
  logic [3:0]    rf_rd_idx, rf_wr_idx;
  logic [63:0]   rf_rd_data, rf_wr_data;
  logic          rf_we;
  logic [63:0]   alu_a, alu_b, alu_res, ld_addr;
  y86_pkg::alu_fn_t alu_fn;
  y86_pkg::cc_t  alu_flags;
  logic [3:0]    srca, srcb;
  logic          cnd_now;

  y86_mem u_mem (
    .clk       (clk),
    .we        (mem_we),
    .waddr     (mem_waddr),
    .wdata     (mem_wdata),
    .raddr     (mem_raddr),
    .rd_data_r (mem_rd)
  );

  y86_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (rf_rd_idx),
    .rd_data (rf_rd_data),
    .we      (rf_we),
    .wr_idx  (rf_wr_idx),
    .wr_data (rf_wr_data)
  );

  y86_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .fn    (alu_fn),
    .res   (alu_res),
    .flags (alu_flags)
  );

  assign fbyte   = rdok_r ? mem_rd : 8'h00;
  assign ld_addr = 64'(in_load_addr);
  assign cnd_now = y86_pkg::cond_ok(cc_r, ifun_r);

  always_comb begin
    case (icode_r) inside
      y86_pkg::I_RRMOVQ, y86_pkg::I_RMMOVQ, y86_pkg::I_OPQ, y86_pkg::I_PUSHQ: srca = ra_r;
      y86_pkg::I_POPQ, y86_pkg::I_RET: srca = y86_pkg::RSP_ID;
      default: srca = y86_pkg::NO_REG;
    endcase
    case (icode_r) inside
      y86_pkg::I_OPQ, y86_pkg::I_RMMOVQ, y86_pkg::I_MRMOVQ: srcb = rb_r;
      y86_pkg::I_PUSHQ, y86_pkg::I_POPQ, y86_pkg::I_CALL, y86_pkg::I_RET:
        srcb = y86_pkg::RSP_ID;
      default: srcb = y86_pkg::NO_REG;
    endcase
  end

  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_fn = y86_pkg::ALU_ADD;
    case (icode_r) inside
      y86_pkg::I_OPQ: begin
        alu_a = vala_r;
        alu_b = valb_r;
        case (ifun_r)
          y86_pkg::F_ADD: alu_fn = y86_pkg::ALU_ADD;
          y86_pkg::F_SUB: alu_fn = y86_pkg::ALU_SUB;
          y86_pkg::F_AND: alu_fn = y86_pkg::ALU_AND;
          y86_pkg::F_XOR: alu_fn = y86_pkg::ALU_XOR;
          default:        alu_fn = y86_pkg::ALU_ZERO;
        endcase
      end
      y86_pkg::I_IRMOVQ: alu_a = valc_r;
      y86_pkg::I_RRMOVQ: alu_a = vala_r;
      y86_pkg::I_RMMOVQ, y86_pkg::I_MRMOVQ: begin
        alu_a = valc_r;
        alu_b = valb_r;
      end
      y86_pkg::I_PUSHQ, y86_pkg::I_CALL: begin
        alu_a  = 64'd8;
        alu_b  = valb_r;
        alu_fn = y86_pkg::ALU_SUB;
      end
      y86_pkg::I_POPQ, y86_pkg::I_RET: begin
        alu_a = 64'd8;
        alu_b = valb_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    stat_nxt    = stat_r;
    cc_nxt      = cc_r;
    clr_nxt     = clr_r;
    pc_nxt      = pc_r;
    faddr_nxt   = faddr_r;
    rdok_nxt    = rdok_r;
    icode_nxt   = icode_r;
    ifun_nxt    = ifun_r;
    ra_nxt      = ra_r;
    rb_nxt      = rb_r;
    valc_nxt    = valc_r;
    vala_nxt    = vala_r;
    valb_nxt    = valb_r;
    vale_nxt    = vale_r;
    valm_nxt    = valm_r;
    wdata_nxt   = wdata_r;
    maddr_nxt   = maddr_r;
    cnt_nxt     = cnt_r;
    cnd_nxt     = cnd_r;
    edest_nxt   = edest_r;
    mdest_nxt   = mdest_r;
    st_done_nxt = st_done_r;
    st_addr_nxt = st_addr_r;
    st_val_nxt  = st_val_r;
    mem_we      = 1'b0;
    mem_waddr   = clr_r;
    mem_wdata   = 8'h00;
    mem_raddr   = faddr_r[AW-1:0];
    rf_rd_idx   = srca;
    rf_we       = 1'b0;
    rf_wr_idx   = edest_r;
    rf_wr_data  = vale_r;

    unique case (state_r)
      y86_pkg::S_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == {AW{1'b1}}) state_nxt = y86_pkg::S_IDLE;
      end
      y86_pkg::S_IDLE: begin
        if (in_valid) begin
          edest_nxt   = y86_pkg::NO_REG;
          mdest_nxt   = y86_pkg::NO_REG;
          ra_nxt      = y86_pkg::NO_REG;
          rb_nxt      = y86_pkg::NO_REG;
          vale_nxt    = '0;
          valm_nxt    = '0;
          valc_nxt    = '0;
          cnd_nxt     = 1'b0;
          st_done_nxt = 1'b0;
          st_addr_nxt = '0;
          st_val_nxt  = '0;
          state_nxt   = y86_pkg::S_OUT;
          if (!in_op) begin
            if (ld_addr < y86_pkg::MEM_LIM) begin
              mem_we    = 1'b1;
              mem_waddr = ld_addr[AW-1:0];
              mem_wdata = in_load_byte;
            end
          end else if (stat_r != y86_pkg::ST_OK) begin
            state_nxt = y86_pkg::S_OUT;
          end else if (pc_r >= y86_pkg::MEM_LIM) begin
            stat_nxt = y86_pkg::ST_ADR;
          end else begin
            mem_raddr = pc_r[AW-1:0];
            faddr_nxt = pc_r + 64'd1;
            state_nxt = y86_pkg::S_FB0;
          end
        end
      end
      y86_pkg::S_FB0: begin
        icode_nxt = mem_rd[7:4];
        ifun_nxt  = mem_rd[3:0];
        cnt_nxt   = '0;
        if (mem_rd[7:4] > y86_pkg::I_POPQ) begin
          stat_nxt  = y86_pkg::ST_INS;
          state_nxt = y86_pkg::S_OUT;
        end else if (y86_pkg::need_reg(mem_rd[7:4])) begin
          rdok_nxt  = faddr_r < y86_pkg::MEM_LIM;
          faddr_nxt = faddr_r + 64'd1;
          state_nxt = y86_pkg::S_FREG;
        end else if (y86_pkg::need_imm(mem_rd[7:4])) begin
          rdok_nxt  = faddr_r < y86_pkg::MEM_LIM;
          faddr_nxt = faddr_r + 64'd1;
          state_nxt = y86_pkg::S_FC;
        end else begin
          state_nxt = y86_pkg::S_RDA;
        end
      end
      y86_pkg::S_FREG: begin
        ra_nxt = fbyte[7:4];
        rb_nxt = fbyte[3:0];
        if (y86_pkg::need_imm(icode_r)) begin
          rdok_nxt  = faddr_r < y86_pkg::MEM_LIM;
          faddr_nxt = faddr_r + 64'd1;
          state_nxt = y86_pkg::S_FC;
        end else begin
          state_nxt = y86_pkg::S_RDA;
        end
      end
      y86_pkg::S_FC: begin
        valc_nxt = {fbyte, valc_r[63:8]};
        cnt_nxt  = cnt_r + 4'd1;
        if (cnt_r == 4'd7) begin
          state_nxt = y86_pkg::S_RDA;
        end else begin
          rdok_nxt  = faddr_r < y86_pkg::MEM_LIM;
          faddr_nxt = faddr_r + 64'd1;
        end
      end
      y86_pkg::S_RDA: begin
        rf_rd_idx = srca;
        vala_nxt  = rf_rd_data;
        state_nxt = y86_pkg::S_RDB;
      end
      y86_pkg::S_RDB: begin
        rf_rd_idx = srcb;
        valb_nxt  = rf_rd_data;
        state_nxt = y86_pkg::S_EXEC;
      end
      y86_pkg::S_EXEC: begin
        vale_nxt  = alu_res;
        cnt_nxt   = '0;
        state_nxt = y86_pkg::S_WBE;
        if (icode_r == y86_pkg::I_OPQ) cc_nxt = alu_flags;
        if (icode_r == y86_pkg::I_RRMOVQ || icode_r == y86_pkg::I_JXX) cnd_nxt = cnd_now;
        case (icode_r) inside
          y86_pkg::I_RRMOVQ: edest_nxt = cnd_now ? rb_r : y86_pkg::NO_REG;
          y86_pkg::I_OPQ, y86_pkg::I_IRMOVQ: edest_nxt = rb_r;
          y86_pkg::I_PUSHQ, y86_pkg::I_POPQ, y86_pkg::I_CALL, y86_pkg::I_RET:
            edest_nxt = y86_pkg::RSP_ID;
          default: ;
        endcase
        if (icode_r == y86_pkg::I_MRMOVQ || icode_r == y86_pkg::I_POPQ) mdest_nxt = ra_r;
        case (icode_r) inside
          y86_pkg::I_HALT: begin
            stat_nxt  = y86_pkg::ST_HLT;
            edest_nxt = y86_pkg::NO_REG;
            state_nxt = y86_pkg::S_OUT;
          end
          y86_pkg::I_RMMOVQ, y86_pkg::I_PUSHQ, y86_pkg::I_CALL: begin
            if (alu_res <= y86_pkg::ADDR_MAX) begin
              maddr_nxt   = alu_res[AW-1:0];
              wdata_nxt   = (icode_r == y86_pkg::I_CALL) ? faddr_r : vala_r;
              st_done_nxt = 1'b1;
              st_addr_nxt = alu_res[11:0];
              st_val_nxt  = (icode_r == y86_pkg::I_CALL) ? faddr_r : vala_r;
              state_nxt   = y86_pkg::S_MEMW;
            end else begin
              stat_nxt = y86_pkg::ST_ADR;
            end
          end
          y86_pkg::I_MRMOVQ: begin
            if (alu_res <= y86_pkg::ADDR_MAX) begin
              maddr_nxt = alu_res[AW-1:0];
              state_nxt = y86_pkg::S_MEMR;
            end else begin
              stat_nxt = y86_pkg::ST_ADR;
            end
          end
          y86_pkg::I_POPQ, y86_pkg::I_RET: begin
            if (vala_r <= y86_pkg::ADDR_MAX) begin
              maddr_nxt = vala_r[AW-1:0];
              state_nxt = y86_pkg::S_MEMR;
            end else begin
              stat_nxt = y86_pkg::ST_ADR;
            end
          end
          default: ;
        endcase
      end
      y86_pkg::S_MEMW: begin
        mem_we    = 1'b1;
        mem_waddr = maddr_r;
        mem_wdata = wdata_r[7:0];
        wdata_nxt = wdata_r >> 8;
        maddr_nxt = maddr_r + 1'b1;
        cnt_nxt   = cnt_r + 4'd1;
        if (cnt_r == 4'd7) state_nxt = y86_pkg::S_WBE;
      end
      y86_pkg::S_MEMR: begin
        mem_raddr = maddr_r;
        maddr_nxt = maddr_r + 1'b1;
        cnt_nxt   = cnt_r + 4'd1;
        if (cnt_r != 4'd0) valm_nxt = {mem_rd, valm_r[63:8]};
        if (cnt_r == 4'd8) state_nxt = y86_pkg::S_WBE;
      end
      y86_pkg::S_WBE: begin
        rf_we      = 1'b1;
        rf_wr_idx  = edest_r;
        rf_wr_data = vale_r;
        state_nxt  = y86_pkg::S_WBM;
      end
      y86_pkg::S_WBM: begin
        rf_we      = 1'b1;
        rf_wr_idx  = mdest_r;
        rf_wr_data = valm_r;
        state_nxt  = y86_pkg::S_OUT;
        if (stat_r == y86_pkg::ST_OK) begin
          case (icode_r)
            y86_pkg::I_CALL: pc_nxt = valc_r;
            y86_pkg::I_RET:  pc_nxt = valm_r;
            y86_pkg::I_JXX:  pc_nxt = cnd_r ? valc_r : faddr_r;
            default:         pc_nxt = faddr_r;
          endcase
        end
      end
      y86_pkg::S_OUT: begin
        if (!out_stall) state_nxt = y86_pkg::S_IDLE;
      end
      default: state_nxt = y86_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= y86_pkg::S_CLEAR;
      stat_r  <= y86_pkg::ST_OK;
      cc_r    <= '0;
      clr_r   <= '0;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      stat_r  <= stat_nxt;
      cc_r    <= cc_nxt;
      clr_r   <= clr_nxt;
      pc_r    <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    faddr_r   <= faddr_nxt;
    rdok_r    <= rdok_nxt;
    icode_r   <= icode_nxt;
    ifun_r    <= ifun_nxt;
    ra_r      <= ra_nxt;
    rb_r      <= rb_nxt;
    valc_r    <= valc_nxt;
    vala_r    <= vala_nxt;
    valb_r    <= valb_nxt;
    vale_r    <= vale_nxt;
    valm_r    <= valm_nxt;
    wdata_r   <= wdata_nxt;
    maddr_r   <= maddr_nxt;
    cnt_r     <= cnt_nxt;
    cnd_r     <= cnd_nxt;
    edest_r   <= edest_nxt;
    mdest_r   <= mdest_nxt;
    st_done_r <= st_done_nxt;
    st_addr_r <= st_addr_nxt;
    st_val_r  <= st_val_nxt;
  end

  assign in_stall          = (state_r != y86_pkg::S_IDLE);
  assign out_valid         = (state_r == y86_pkg::S_OUT);
  assign out_pc            = pc_r;
  assign out_status        = 2'(stat_r);
  assign out_zero_flag     = cc_r.zf;
  assign out_sign_flag     = cc_r.sf;
  assign out_overflow_flag = cc_r.of;
  assign out_e_dest        = edest_r;
  assign out_e_value       = (edest_r != y86_pkg::NO_REG) ? vale_r : 64'd0;
  assign out_m_dest        = mdest_r;
  assign out_m_value       = (mdest_r != y86_pkg::NO_REG) ? valm_r : 64'd0;
  assign out_store_done    = st_done_r;
  assign out_store_addr    = st_addr_r;
  assign out_store_value   = st_val_r;

  a_stat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (stat_r != y86_pkg::ST_OK) |=> $stable(stat_r))
    else $error("status left a stopped state");

  a_store_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_store_done) |-> (out_status == 2'(y86_pkg::ST_OK)))
    else $error("store reported with non-ok status");

  a_memw_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == y86_pkg::S_MEMW) |-> (stat_r == y86_pkg::ST_OK && st_done_r))
    else $error("memory write outside an ok store");

endmodule

### sv/y86_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y86_mem
// Byte-wide main memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module y86_mem (
  input  logic                   clk,
  input  logic                   we,
  input  logic [y86_pkg::AW-1:0] waddr,
  input  logic [7:0]             wdata,
  input  logic [y86_pkg::AW-1:0] raddr,
  output logic [7:0]             rd_data_r
);

  logic [7:0] mem [y86_pkg::MEM_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

endmodule

### sv/y86_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y86_regs
// Fifteen 64-bit registers with per-entry valid bits; id 15 reads zero.
// ----------------------------------------------------------------------------
module y86_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [3:0]  rd_idx,
  output logic [63:0] rd_data,
  input  logic        we,
  input  logic [3:0]  wr_idx,
  input  logic [63:0] wr_data
);

  logic [63:0] regs_r [15];
  logic [14:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we && wr_idx != y86_pkg::NO_REG) begin
      vld_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we && wr_idx != y86_pkg::NO_REG) begin
      regs_r[wr_idx] <= wr_data;
    end
  end

  always_comb begin
    if (rd_idx == y86_pkg::NO_REG || !vld_r[rd_idx]) begin
      rd_data = '0;
    end else begin
      rd_data = regs_r[rd_idx];
    end
  end

endmodule

### sv/y86_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// y86_alu
// Shared 64-bit unit: b op a for add, sub, and, xor (else zero), with condition flags.
// ----------------------------------------------------------------------------
module y86_alu (
  input  logic [63:0]      a,
  input  logic [63:0]      b,
  input  y86_pkg::alu_fn_t fn,
  output logic [63:0]      res,
  output y86_pkg::cc_t     flags
);

  logic na, nb, nr, pa, pb;

  always_comb begin
    unique case (fn)
      y86_pkg::ALU_ADD: res = b + a;
      y86_pkg::ALU_SUB: res = b - a;
      y86_pkg::ALU_AND: res = b & a;
      y86_pkg::ALU_XOR: res = b ^ a;
      default:          res = '0;
    endcase
    na = a[63];
    nb = b[63];
    nr = res[63];
    pa = !na && (a != '0);
    pb = !nb && (b != '0);
    flags.zf = (res == '0);
    flags.sf = nr;
    case (fn)
      y86_pkg::ALU_ADD: flags.of = (pa && pb && nr) || (na && nb && !nr);
      y86_pkg::ALU_SUB: flags.of = (pb && na && nr) || (nb && pa && !nr);
      default:          flags.of = 1'b0;
    endcase
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the sequential Y86-64 core with program-byte loads and instruction
// steps. Programs are generated one instruction at a time at the current pc
// from an architectural model kept here. Each result word is compared field
// by field with the model's prediction, under random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct {
    logic [63:0] pc;
    logic [1:0]  status;
    logic        zf;
    logic        sf;
    logic        of;
    logic [3:0]  e_dest;
    logic [63:0] e_value;
    logic [3:0]  m_dest;
    logic [63:0] m_value;
    logic        store_done;
    logic [11:0] store_addr;
    logic [63:0] store_value;
  } core_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = 1'b0;
  logic [11:0] in_load_addr = '0;
  logic [7:0]  in_load_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [63:0] out_pc;
  logic [1:0]  out_status;
  logic        out_zero_flag;
  logic        out_sign_flag;
  logic        out_overflow_flag;
  logic [3:0]  out_e_dest;
  logic signed [63:0] out_e_value;
  logic [3:0]  out_m_dest;
  logic signed [63:0] out_m_value;
  logic        out_store_done;
  logic [11:0] out_store_addr;
  logic signed [63:0] out_store_value;

  y86_sequential_processor u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_load_addr(in_load_addr), .in_load_byte(in_load_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_pc(out_pc),
    .out_status(out_status), .out_zero_flag(out_zero_flag),
    .out_sign_flag(out_sign_flag), .out_overflow_flag(out_overflow_flag),
    .out_e_dest(out_e_dest), .out_e_value(out_e_value),
    .out_m_dest(out_m_dest), .out_m_value(out_m_value),
    .out_store_done(out_store_done), .out_store_addr(out_store_addr),
    .out_store_value(out_store_value)
  );

  always #6 clk = ~clk;

  // architectural state of the core
  logic [7:0]  arch_mem [0:y86_pkg::MEM_BYTES-1];
  logic [63:0] arch_regs [0:14];
  logic [63:0] arch_pc;
  logic        arch_zf, arch_sf, arch_of;
  y86_pkg::stat_t arch_stat;

  core_out_t   expected_q [$];
  logic [7:0]  prog_bytes [$];
  int          words_sent = 0;
  int          errors = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;

  function automatic logic [63:0] mem_byte(input logic [63:0] a);
    return (a < y86_pkg::MEM_LIM) ? {56'd0, arch_mem[a[11:0]]} : 64'd0;
  endfunction

  function automatic logic [63:0] reg_rd(input logic [3:0] r);
    return (r != y86_pkg::NO_REG) ? arch_regs[r] : 64'd0;
  endfunction

  function automatic logic cond_holds(input logic [3:0] fn);
    logic lt;
    lt = arch_sf ^ arch_of;
    case (fn)
      y86_pkg::C_ALW: return 1'b1;
      y86_pkg::C_LE:  return lt | arch_zf;
      y86_pkg::C_L:   return lt;
      y86_pkg::C_E:   return arch_zf;
      y86_pkg::C_NE:  return ~arch_zf;
      y86_pkg::C_GE:  return ~lt;
      y86_pkg::C_G:   return ~lt & ~arch_zf;
      default: return 1'b0;
    endcase
  endfunction

  task automatic y86_step(input logic op, input logic [11:0] la, input logic [7:0] lb,
                          output core_out_t r);
    logic [7:0]  b0, b1;
    logic [3:0]  icode, ifun, ra, rb, srca, srcb, e_dst, m_dst;
    logic [63:0] valp, valc, vala, valb, vale, valm, wv, rd_a;
    logic        cnd, ovf;
    int          i;
    e_dst = y86_pkg::NO_REG;
    m_dst = y86_pkg::NO_REG;
    vale = '0;
    valm = '0;
    r.store_done = 1'b0;
    r.store_addr = '0;
    r.store_value = '0;
    if (!op) begin
      arch_mem[la] = lb;
    end else if (arch_stat == y86_pkg::ST_OK) begin
      if (arch_pc >= y86_pkg::MEM_LIM) begin
        arch_stat = y86_pkg::ST_ADR;
      end else begin
        b0 = arch_mem[arch_pc[11:0]];
        icode = b0[7:4];
        ifun = b0[3:0];
        if (icode > y86_pkg::I_POPQ) begin
          arch_stat = y86_pkg::ST_INS;
        end else begin
          valp = arch_pc + 64'd1;
          valc = '0;
          ra = y86_pkg::NO_REG;
          rb = y86_pkg::NO_REG;
          srca = y86_pkg::NO_REG;
          srcb = y86_pkg::NO_REG;
          cnd = 1'b0;
          if (icode inside {y86_pkg::I_RRMOVQ, y86_pkg::I_IRMOVQ, y86_pkg::I_RMMOVQ,
                            y86_pkg::I_MRMOVQ, y86_pkg::I_OPQ, y86_pkg::I_PUSHQ,
                            y86_pkg::I_POPQ}) begin
            b1 = 8'(mem_byte(valp));
            ra = b1[7:4];
            rb = b1[3:0];
            valp = valp + 64'd1;
          end
          if (icode inside {y86_pkg::I_IRMOVQ, y86_pkg::I_RMMOVQ, y86_pkg::I_MRMOVQ,
                            y86_pkg::I_JXX, y86_pkg::I_CALL}) begin
            for (i = 0; i < 8; i++) valc |= mem_byte(valp + i) << (8 * i);
            valp = valp + 64'd8;
          end
          if (icode inside {y86_pkg::I_RRMOVQ, y86_pkg::I_RMMOVQ, y86_pkg::I_OPQ,
                            y86_pkg::I_PUSHQ}) srca = ra;
          else if (icode inside {y86_pkg::I_POPQ, y86_pkg::I_RET}) srca = y86_pkg::RSP_ID;
          vala = reg_rd(srca);
          if (icode inside {y86_pkg::I_OPQ, y86_pkg::I_RMMOVQ, y86_pkg::I_MRMOVQ}) srcb = rb;
          else if (icode inside {y86_pkg::I_PUSHQ, y86_pkg::I_POPQ, y86_pkg::I_CALL,
                                 y86_pkg::I_RET}) srcb = y86_pkg::RSP_ID;
          valb = reg_rd(srcb);

          if (icode == y86_pkg::I_OPQ) begin
            ovf = 1'b0;
            case (ifun)
              y86_pkg::F_ADD: vale = valb + vala;
              y86_pkg::F_SUB: vale = valb - vala;
              y86_pkg::F_AND: vale = valb & vala;
              y86_pkg::F_XOR: vale = valb ^ vala;
              default: vale = '0;
            endcase
            if (ifun == y86_pkg::F_ADD)
              ovf = (!vala[63] && vala != 0 && !valb[63] && valb != 0 && vale[63]) ||
                    (vala[63] && valb[63] && !vale[63]);
            else if (ifun == y86_pkg::F_SUB)
              ovf = (!valb[63] && valb != 0 && vala[63] && vale[63]) ||
                    (valb[63] && !vala[63] && vala != 0 && !vale[63]);
            arch_zf = (vale == 0);
            arch_sf = vale[63];
            arch_of = ovf;
          end else if (icode == y86_pkg::I_IRMOVQ) vale = valc;
          else if (icode == y86_pkg::I_RRMOVQ) vale = vala;
          else if (icode inside {y86_pkg::I_RMMOVQ, y86_pkg::I_MRMOVQ}) vale = valb + valc;
          else if (icode inside {y86_pkg::I_PUSHQ, y86_pkg::I_CALL}) vale = valb - 64'd8;
          else if (icode inside {y86_pkg::I_POPQ, y86_pkg::I_RET}) vale = valb + 64'd8;
          if (icode inside {y86_pkg::I_JXX, y86_pkg::I_RRMOVQ}) cnd = cond_holds(ifun);
          if (icode == y86_pkg::I_HALT) arch_stat = y86_pkg::ST_HLT;

          if (icode inside {y86_pkg::I_RMMOVQ, y86_pkg::I_PUSHQ, y86_pkg::I_CALL}) begin
            wv = (icode == y86_pkg::I_CALL) ? valp : vala;
            if (vale <= y86_pkg::ADDR_MAX) begin
              for (i = 0; i < 8; i++) arch_mem[vale[11:0] + i] = wv[8*i +: 8];
              r.store_done = 1'b1;
              r.store_addr = vale[11:0];
              r.store_value = wv;
            end else begin
              arch_stat = y86_pkg::ST_ADR;
            end
          end else if (icode inside {y86_pkg::I_MRMOVQ, y86_pkg::I_POPQ,
                                     y86_pkg::I_RET}) begin
            rd_a = (icode == y86_pkg::I_MRMOVQ) ? vale : vala;
            if (rd_a <= y86_pkg::ADDR_MAX) begin
              for (i = 0; i < 8; i++) valm |= {56'd0, arch_mem[rd_a[11:0] + i]} << (8 * i);
            end else begin
              arch_stat = y86_pkg::ST_ADR;
            end
          end

          if (icode == y86_pkg::I_RRMOVQ) begin
            if (cnd) e_dst = rb;
          end else if (icode inside {y86_pkg::I_OPQ, y86_pkg::I_IRMOVQ}) e_dst = rb;
          else if (icode inside {y86_pkg::I_PUSHQ, y86_pkg::I_POPQ, y86_pkg::I_CALL,
                                 y86_pkg::I_RET}) e_dst = y86_pkg::RSP_ID;
          if (e_dst != y86_pkg::NO_REG) arch_regs[e_dst] = vale;
          if (icode inside {y86_pkg::I_MRMOVQ, y86_pkg::I_POPQ}) m_dst = ra;
          if (m_dst != y86_pkg::NO_REG) arch_regs[m_dst] = valm;

          if (arch_stat == y86_pkg::ST_OK) begin
            if (icode == y86_pkg::I_CALL) arch_pc = valc;
            else if (icode == y86_pkg::I_RET) arch_pc = valm;
            else if (icode == y86_pkg::I_JXX) arch_pc = cnd ? valc : valp;
            else arch_pc = valp;
          end
        end
      end
    end
    r.pc = arch_pc;
    r.status = arch_stat;
    r.zf = arch_zf;
    r.sf = arch_sf;
    r.of = arch_of;
    r.e_dest = e_dst;
    r.e_value = (e_dst != y86_pkg::NO_REG) ? vale : 64'd0;
    r.m_dest = m_dst;
    r.m_value = (m_dst != y86_pkg::NO_REG) ? valm : 64'd0;
  endtask

  task automatic send_word(input logic op, input logic [11:0] a, input logic [7:0] d);
    core_out_t e;
    in_valid <= 1'b1;
    in_op <= op;
    in_load_addr <= a;
    in_load_byte <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    y86_step(op, a, d, e);
    expected_q.push_back(e);
    words_sent++;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic put_quad(input logic [63:0] v);
    for (int i = 0; i < 8; i++) prog_bytes.push_back(v[8*i +: 8]);
  endtask

  // load the queued bytes at pc, then step once
  task automatic run_program();
    logic [11:0] base;
    base = arch_pc[11:0];
    foreach (prog_bytes[i]) send_word(1'b0, base + i[11:0], prog_bytes[i]);
    send_word(1'b1, 12'($urandom), 8'($urandom));
    prog_bytes.delete();
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 6))
      0: return 64'd0;
      1: return 64'd1;
      2: return '1;
      3: return 64'h8000_0000_0000_0000;
      4: return 64'h7FFF_FFFF_FFFF_FFFF;
      5: return 64'($urandom_range(0, 300));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] code_target();
    return 64'($urandom_range(0, 12'h6F0));
  endfunction

  task automatic gen_instruction();
    logic [3:0]  ra, rb;
    logic [63:0] rsp, tgt;
    int          pick;
    ra = 4'($urandom);
    rb = 4'($urandom);
    rsp = arch_regs[y86_pkg::RSP_ID];
    pick = $urandom_range(0, 99);
    if (arch_pc > 64'h6F0) begin
      prog_bytes.push_back({y86_pkg::I_JXX, y86_pkg::C_ALW});
      put_quad(code_target());
    end else if (pick >= 76 && !(rsp >= 64'h808 && rsp <= 64'hFF8)) begin
      prog_bytes.push_back({y86_pkg::I_IRMOVQ, 4'h0});
      prog_bytes.push_back({4'hF, y86_pkg::RSP_ID});
      put_quad(64'h900 + 8 * $urandom_range(0, 200));
    end else if (pick < 5) begin
      prog_bytes.push_back({y86_pkg::I_NOP, 4'($urandom)});
    end else if (pick < 20) begin
      prog_bytes.push_back({y86_pkg::I_IRMOVQ, 4'h0});
      prog_bytes.push_back({4'hF, rb});
      put_quad(pick_value());
    end else if (pick < 30) begin
      prog_bytes.push_back({y86_pkg::I_RRMOVQ, 4'($urandom_range(0, 8))});
      prog_bytes.push_back({ra, rb});
    end else if (pick < 52) begin
      prog_bytes.push_back({y86_pkg::I_OPQ, ($urandom_range(0, 9) < 8)
                                             ? 4'($urandom_range(0, 3)) : 4'($urandom)});
      prog_bytes.push_back({ra, rb});
    end else if (pick < 60) begin
      prog_bytes.push_back({y86_pkg::I_JXX, 4'($urandom_range(0, 8))});
      put_quad(code_target());
    end else if (pick < 68) begin
      tgt = 64'h800 + $urandom_range(0, 12'h7F8);
      prog_bytes.push_back({(pick < 64) ? y86_pkg::I_RMMOVQ : y86_pkg::I_MRMOVQ, 4'h0});
      prog_bytes.push_back({ra, rb});
      put_quad(tgt - reg_rd(rb));
    end else if (pick < 76) begin
      prog_bytes.push_back({y86_pkg::I_RMMOVQ, 4'h0});
      prog_bytes.push_back({ra, 4'hF});
      put_quad(64'h800 + $urandom_range(0, 12'h7F8));
    end else if (pick < 83) begin
      prog_bytes.push_back({y86_pkg::I_PUSHQ, 4'h0});
      prog_bytes.push_back({ra, rb});
    end else if (pick < 90) begin
      prog_bytes.push_back({y86_pkg::I_POPQ, 4'h0});
      prog_bytes.push_back({ra, rb});
    end else if (pick < 95) begin
      prog_bytes.push_back({y86_pkg::I_CALL, 4'h0});
      put_quad(code_target());
    end else begin
      for (int i = 0; i < 8; i++) tgt[8*i +: 8] = arch_mem[rsp[11:0] + i];
      prog_bytes.push_back((tgt <= 64'h6F0) ? {y86_pkg::I_RET, 4'h0}
                                            : {y86_pkg::I_NOP, 4'h0});
    end
    run_program();
  endtask

  task automatic random_until(input int target);
    while (words_sent < target) begin
      if ($urandom_range(0, 9) == 0) send_word(1'b0, 12'($urandom), 8'($urandom));
      else gen_instruction();
    end
  endtask

  task automatic test_directed();
    send_word(1'b0, 12'hFFF, 8'hFF);
    send_word(1'b0, 12'h000, 8'h00);
    prog_bytes.push_back({y86_pkg::I_IRMOVQ, 4'h0});
    prog_bytes.push_back({4'hF, 4'h0});
    put_quad(64'h7FFF_FFFF_FFFF_FFFF);
    run_program();
    prog_bytes.push_back({y86_pkg::I_OPQ, y86_pkg::F_ADD});
    prog_bytes.push_back({4'h0, 4'h0});
    run_program();
    prog_bytes.push_back({y86_pkg::I_OPQ, 4'hF});
    prog_bytes.push_back({4'hF, 4'hF});
    run_program();
  endtask

  task automatic test_random_idle();
    random_until(260);
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    random_until(words_sent + 20);
  endtask

  task automatic test_steady_flow();
    random_until(330);
    idle_on = 1'b0;
    random_until(430);
  endtask

  task automatic test_stopped_core();
    case ($urandom_range(0, 4))
      0: prog_bytes.push_back({y86_pkg::I_HALT, 4'($urandom)});
      1: prog_bytes.push_back({4'($urandom_range(12, 15)), 4'($urandom)});
      2: begin
        prog_bytes.push_back({y86_pkg::I_MRMOVQ, 4'h0});
        prog_bytes.push_back({4'($urandom), 4'hF});
        put_quad(($urandom_range(0, 1) == 0)
                 ? 64'(y86_pkg::ADDR_MAX + $urandom_range(1, 7))
                 : {$urandom, $urandom} | 64'h1000);
      end
      3: begin
        prog_bytes.push_back({y86_pkg::I_JXX, y86_pkg::C_ALW});
        put_quad(64'hFFC);
        run_program();
        prog_bytes.push_back({y86_pkg::I_IRMOVQ, 4'h0});
        prog_bytes.push_back({4'hF, 4'($urandom_range(0, 14))});
        prog_bytes.push_back(8'($urandom));
        prog_bytes.push_back(8'($urandom));
      end
      default: begin
        prog_bytes.push_back({y86_pkg::I_JXX, y86_pkg::C_ALW});
        put_quad({1'b1, 31'($urandom), $urandom});
      end
    endcase
    run_program();
    repeat (12) send_word(1'($urandom), 12'($urandom), 8'($urandom));
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h, want %h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    core_out_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word", out_pc, 64'd0);
      end else begin
        w = expected_q.pop_front();
        if (out_pc !== w.pc) report_mismatch("pc", out_pc, w.pc);
        if (out_status !== w.status) report_mismatch("status", out_status, w.status);
        if (out_zero_flag !== w.zf) report_mismatch("zero_flag", out_zero_flag, w.zf);
        if (out_sign_flag !== w.sf) report_mismatch("sign_flag", out_sign_flag, w.sf);
        if (out_overflow_flag !== w.of)
          report_mismatch("overflow_flag", out_overflow_flag, w.of);
        if (out_e_dest !== w.e_dest) report_mismatch("e_dest", out_e_dest, w.e_dest);
        if (out_e_value !== w.e_value) report_mismatch("e_value", out_e_value, w.e_value);
        if (out_m_dest !== w.m_dest) report_mismatch("m_dest", out_m_dest, w.m_dest);
        if (out_m_value !== w.m_value) report_mismatch("m_value", out_m_value, w.m_value);
        if (out_store_done !== w.store_done)
          report_mismatch("store_done", out_store_done, w.store_done);
        if (out_store_addr !== w.store_addr)
          report_mismatch("store_addr", out_store_addr, w.store_addr);
        if (out_store_value !== w.store_value)
          report_mismatch("store_value", out_store_value, w.store_value);
      end
    end
  end

  // receiver side: random stalls, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (90) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #(6_000_000);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    for (int i = 0; i < y86_pkg::MEM_BYTES; i++) arch_mem[i] = '0;
    for (int i = 0; i < 15; i++) arch_regs[i] = '0;
    arch_pc = '0;
    arch_zf = 1'b0;
    arch_sf = 1'b0;
    arch_of = 1'b0;
    arch_stat = y86_pkg::ST_OK;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_idle();
    test_backpressure();
    test_steady_flow();
    test_stopped_core();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
